// File: rtl/ryas_pkg.sv
// Shared constants, types and coefficient tables for the RGB to YUV 4:2:0 core.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ryas_pkg;

  // Widest line the chroma line store supports, and the coefficient precision.
  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 15;

  // Field and register widths.
  localparam int PIX_W   = 8;
  localparam int ALPHA_W = 9;
  localparam int DIM_W   = 13;
  localparam int CFG_W   = DIM_W;
  localparam int CNT_W   = DIM_W + 1;   // room for width, count + 1 and the width limit

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = COL_W - 1;
  localparam int W_LIMIT    = MAX_WIDTH - (MAX_WIDTH % 2);

  // Arithmetic widths.
  localparam int SCALE_W = PIX_W + ALPHA_W;          // channel * alpha_gain
  localparam int COEF_W  = COEF_FRAC_BITS + 2;       // signed, magnitude below one
  localparam int PROD_W  = COEF_W + SCALE_W + 1;
  localparam int ACC_W   = COEF_FRAC_BITS + 22;
  localparam int OUT_SHIFT = COEF_FRAC_BITS + 8;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ALPHA_GAIN   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  // Position of a pixel in the frame, carried with it down the pipeline.
  typedef struct packed {
    logic [LINE_AW-1:0] idx;
    logic               col_odd;
    logic               row_odd;
    logic               eof;
  } pix_pos_t;

  // Read request into the chroma line store.
  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] idx;
  } line_rd_t;

  // Coefficient in millionths to signed fixed point, rounded half away from zero.
  function automatic coef_t quant_coef(longint micro);
    longint mag;
    longint q;
    mag = (micro < 0) ? -micro : micro;
    q   = ((mag << COEF_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    return (micro < 0) ? coef_t'(-q) : coef_t'(q);
  endfunction

  // Rows: Y, U, V. Columns: red, green, blue.
  localparam coef_t COEF_M [3][3] = '{
    '{quant_coef(256788),  quant_coef(504129),  quant_coef(97906)},
    '{quant_coef(-148223), quant_coef(-290993), quant_coef(439216)},
    '{quant_coef(439216),  quant_coef(-367788), quant_coef(-71427)}
  };

  // Output offset plus the half LSB used for round half up.
  localparam acc_t ACC_INIT [3] = '{
    acc_t'((longint'(16)  << OUT_SHIFT) + (longint'(1) << (OUT_SHIFT - 1))),
    acc_t'((longint'(128) << OUT_SHIFT) + (longint'(1) << (OUT_SHIFT - 1))),
    acc_t'((longint'(128) << OUT_SHIFT) + (longint'(1) << (OUT_SHIFT - 1)))
  };

endpackage

`default_nettype wire

// File: rtl/rgb_to_yuv420_alpha_scale_core.sv
// Top level of the RGB to YUV 4:2:0 converter with alpha scaling.
// Depends on ryas_pkg, ryas_frame_ctr, ryas_csc and ryas_chroma.
//
// Usage:
// Pixels arrive in raster order on the pixel channel (red, green, blue and
// start_of_frame, with pixel_valid / pixel_ready). Each pixel is scaled by
// alpha_gain/256 and converted to BT.601 studio-range Y, U and V. Every
// request yields one result on the result channel (result_valid /
// result_ready): luma for the pixel, plus chroma_u / chroma_v averaged over
// the 2x2 block when chroma_valid is set (odd row, odd column), and
// end_of_frame on the last pixel of the frame.
// Throughput is one pixel per clock while result_ready stays high. Each
// request passes the stages in order: one stage scales, one forms the nine
// matrix products, one sums and saturates, and the result register follows.
// The chroma line store is a single-port-write, registered-read memory of
// MAX_WIDTH/2 words holding the even-row pair sums; its read is issued one
// stage ahead of use, so the memory latency is hidden in the pipeline.
// When the receiver stalls, the pipeline stages fill in turn and pixel_ready
// drops only once every stage holds a request.
// Reset empties the pipeline, clears the frame counters and restores
// alpha_gain 256, frame_width 640 and frame_height 480. The line store is not
// cleared; it is written during each even row before it is read.
// The cfg port writes one register per cycle with cfg_we; write it only while
// no request is in flight.
`default_nettype none

module rgb_to_yuv420_alpha_scale_core
  import ryas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             pixel_valid,
  output logic                  pixel_ready,
  input  wire logic [PIX_W-1:0] red,
  input  wire logic [PIX_W-1:0] green,
  input  wire logic [PIX_W-1:0] blue,
  input  wire logic             start_of_frame,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [PIX_W-1:0]      luma,
  output logic                  chroma_valid,
  output logic [PIX_W-1:0]      chroma_u,
  output logic [PIX_W-1:0]      chroma_v,
  output logic                  end_of_frame
);

  logic [ALPHA_W-1:0] alpha_gain;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;

  pix_pos_t         pix_pos;
  logic             csc_valid;
  logic             csc_ready;
  logic [PIX_W-1:0] csc_y;
  logic [PIX_W-1:0] csc_u;
  logic [PIX_W-1:0] csc_v;
  pix_pos_t         csc_pos;
  line_rd_t         line_rd;

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain   <= ALPHA_W'(256);
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA_GAIN:   alpha_gain   <= cfg_data[ALPHA_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counters move on each accepted request and tag it with its frame position.
  ryas_frame_ctr u_frame_ctr (
    .clk            (clk),
    .rst            (rst),
    .accept         (pixel_valid && pixel_ready),
    .start_of_frame (start_of_frame),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .pos            (pix_pos)
  );

  ryas_csc u_csc (
    .clk        (clk),
    .rst        (rst),
    .alpha_gain (alpha_gain),
    .pix_valid  (pixel_valid),
    .pix_ready  (pixel_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .pix_pos    (pix_pos),
    .csc_valid  (csc_valid),
    .csc_ready  (csc_ready),
    .csc_y      (csc_y),
    .csc_u      (csc_u),
    .csc_v      (csc_v),
    .csc_pos    (csc_pos),
    .line_rd    (line_rd)
  );

  ryas_chroma u_chroma (
    .clk          (clk),
    .rst          (rst),
    .csc_valid    (csc_valid),
    .csc_ready    (csc_ready),
    .csc_y        (csc_y),
    .csc_u        (csc_u),
    .csc_v        (csc_v),
    .csc_pos      (csc_pos),
    .line_rd      (line_rd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v),
    .end_of_frame (end_of_frame)
  );

endmodule

`default_nettype wire

// File: rtl/ryas_frame_ctr.sv
// Column and row counters that place each accepted pixel in the frame.
// Depends on ryas_pkg.
`default_nettype none

module ryas_frame_ctr
  import ryas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             start_of_frame,
  input  wire logic [DIM_W-1:0] frame_width,
  input  wire logic [DIM_W-1:0] frame_height,
  output pix_pos_t              pos
);

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count_next;

  logic [CNT_W-1:0] width_eff;
  logic [CNT_W-1:0] height_eff;
  logic [CNT_W-1:0] col_cur;
  logic [CNT_W-1:0] row_cur;

  // Clear bit 0, then clamp to the supported range.
  always_comb begin
    width_eff = {1'b0, frame_width[DIM_W-1:1], 1'b0};
    if (width_eff < CNT_W'(2)) begin
      width_eff = CNT_W'(2);
    end
    if (width_eff > CNT_W'(W_LIMIT)) begin
      width_eff = CNT_W'(W_LIMIT);
    end
    height_eff = {1'b0, frame_height[DIM_W-1:1], 1'b0};
    if (height_eff < CNT_W'(2)) begin
      height_eff = CNT_W'(2);
    end
    if (height_eff > CNT_W'(MAX_HEIGHT)) begin
      height_eff = CNT_W'(MAX_HEIGHT);
    end
  end

  always_comb begin
    col_cur = start_of_frame ? '0 : CNT_W'(column_count);
    row_cur = start_of_frame ? '0 : CNT_W'(row_count);

    pos.idx     = col_cur[COL_W-1:1];
    pos.col_odd = col_cur[0];
    pos.row_odd = row_cur[0];
    pos.eof     = (col_cur == width_eff - CNT_W'(1)) &&
                  (row_cur == height_eff - CNT_W'(1));

    if (col_cur + CNT_W'(1) >= width_eff) begin
      column_count_next = '0;
      if (row_cur + CNT_W'(1) >= height_eff) begin
        row_count_next = '0;
      end else begin
        row_count_next = ROW_W'(row_cur + CNT_W'(1));
      end
    end else begin
      column_count_next = COL_W'(col_cur + CNT_W'(1));
      row_count_next    = row_cur[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ryas_csc.sv
// Three-stage color conversion pipeline: alpha scale, matrix products, sum and saturate.
// Depends on ryas_pkg; issues the line store read for chroma rows.
`default_nettype none

module ryas_csc
  import ryas_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [ALPHA_W-1:0] alpha_gain,
  input  wire logic               pix_valid,
  output logic                    pix_ready,
  input  wire logic [PIX_W-1:0]   red,
  input  wire logic [PIX_W-1:0]   green,
  input  wire logic [PIX_W-1:0]   blue,
  input  wire pix_pos_t           pix_pos,
  output logic                    csc_valid,
  input  wire logic               csc_ready,
  output logic [PIX_W-1:0]        csc_y,
  output logic [PIX_W-1:0]        csc_u,
  output logic [PIX_W-1:0]        csc_v,
  output pix_pos_t                csc_pos,
  output line_rd_t                line_rd
);

  function automatic logic [PIX_W-1:0] sat8(acc_t a);
    acc_t q;
    q = a >>> OUT_SHIFT;
    if (a < 0) begin
      return '0;
    end else if (q > acc_t'(255)) begin
      return '1;
    end else begin
      return q[PIX_W-1:0];
    end
  endfunction

  logic en1, en2, en3;
  logic v1, v2, v3;

  logic [SCALE_W-1:0]      scaled1 [3];
  pix_pos_t                pos1;
  logic signed [PROD_W-1:0] prod2  [3][3];
  pix_pos_t                pos2;
  logic [PIX_W-1:0]        yuv3    [3];
  pix_pos_t                pos3;

  acc_t acc [3];
  logic [PIX_W-1:0] chan [3];

  // Stages advance independently, so bubbles are squeezed out under stall.
  assign en3       = !v3 || csc_ready;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign pix_ready = en1;

  assign chan[0] = red;
  assign chan[1] = green;
  assign chan[2] = blue;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = ACC_INIT[k] + acc_t'(prod2[k][0]) + acc_t'(prod2[k][1]) +
               acc_t'(prod2[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= pix_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        scaled1[i] <= SCALE_W'(chan[i]) * SCALE_W'(alpha_gain);
      end
      pos1 <= pix_pos;
    end
    if (en2) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod2[k][i] <= COEF_M[k][i] * $signed({1'b0, scaled1[i]});
        end
      end
      pos2 <= pos1;
    end
    if (en3) begin
      for (int k = 0; k < 3; k++) begin
        yuv3[k] <= sat8(acc[k]);
      end
      pos3 <= pos2;
    end
  end

  // The pair sum is fetched as an odd-row, odd-column pixel enters the last stage.
  assign line_rd.en  = en3 && v2 && pos2.col_odd && pos2.row_odd;
  assign line_rd.idx = pos2.idx;

  assign csc_valid = v3;
  assign csc_y     = yuv3[0];
  assign csc_u     = yuv3[1];
  assign csc_v     = yuv3[2];
  assign csc_pos   = pos3;

endmodule

`default_nettype wire

// File: rtl/ryas_chroma.sv
// Chroma 2x2 averaging around the pair-sum line store, plus the result register.
// Depends on ryas_pkg; fed by ryas_csc.
`default_nettype none

module ryas_chroma
  import ryas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             csc_valid,
  output logic                  csc_ready,
  input  wire logic [PIX_W-1:0] csc_y,
  input  wire logic [PIX_W-1:0] csc_u,
  input  wire logic [PIX_W-1:0] csc_v,
  input  wire pix_pos_t         csc_pos,
  input  wire line_rd_t         line_rd,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [PIX_W-1:0]      luma,
  output logic                  chroma_valid,
  output logic [PIX_W-1:0]      chroma_u,
  output logic [PIX_W-1:0]      chroma_v,
  output logic                  end_of_frame
);

  // U pair sum in the upper half, V pair sum in the lower half.
  logic [2*PIX_W+1:0] line_mem [LINE_DEPTH];
  logic [2*PIX_W+1:0] rd_data;
  logic               rd_armed;

  logic [PIX_W-1:0] held_u;
  logic [PIX_W-1:0] held_v;

  logic             take;
  logic             is_even_col;
  logic             mem_we;
  logic             is_reader;
  logic [PIX_W:0]   pair_u;
  logic [PIX_W:0]   pair_v;
  logic [PIX_W+1:0] quad_u;
  logic [PIX_W+1:0] quad_v;

  assign csc_ready   = !result_valid || result_ready;
  assign take        = csc_valid && csc_ready;
  assign is_even_col = take && !csc_pos.col_odd;
  assign mem_we      = take && csc_pos.col_odd && !csc_pos.row_odd;
  assign is_reader   = take && csc_pos.col_odd && csc_pos.row_odd;

  assign pair_u = {1'b0, held_u} + {1'b0, csc_u};
  assign pair_v = {1'b0, held_v} + {1'b0, csc_v};
  assign quad_u = {1'b0, pair_u} + {1'b0, rd_data[2*PIX_W+1:PIX_W+1]};
  assign quad_v = {1'b0, pair_v} + {1'b0, rd_data[PIX_W:0]};

  // Writes come from even rows and reads from the odd row after, at least one pixel
  // apart in the pipeline, so a read never meets a pending write of its own entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[csc_pos.idx] <= {pair_u, pair_v};
    end
  end

  always_ff @(posedge clk) begin
    if (line_rd.en) begin
      rd_data <= line_mem[line_rd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_armed <= 1'b0;
      held_u   <= '0;
      held_v   <= '0;
    end else begin
      if (line_rd.en) begin
        rd_armed <= 1'b1;
      end else if (take) begin
        rd_armed <= 1'b0;
      end
      if (is_even_col) begin
        held_u <= csc_u;
        held_v <= csc_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (csc_ready) begin
      result_valid <= csc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      luma         <= csc_y;
      chroma_valid <= is_reader;
      chroma_u     <= is_reader ? quad_u[PIX_W+1:2] : '0;
      chroma_v     <= is_reader ? quad_v[PIX_W+1:2] : '0;
      end_of_frame <= csc_pos.eof;
    end
  end

  // An averaging pixel always finds its pair sum already fetched.
  a_read_before_use : assert property (@(posedge clk) disable iff (rst)
    is_reader |-> rd_armed)
    else $error("chroma pixel consumed without a line store read");

  // A read and a write never target the same entry in one cycle.
  a_no_rw_collision : assert property (@(posedge clk) disable iff (rst)
    (line_rd.en && mem_we) |-> (line_rd.idx != csc_pos.idx))
    else $error("line store read and write collide");

  // The last pixel of a frame sits on an odd row and odd column.
  a_eof_has_chroma : assert property (@(posedge clk) disable iff (rst)
    (result_valid && end_of_frame) |-> chroma_valid)
    else $error("end of frame without a chroma sample");

endmodule

`default_nettype wire
